// ----- hw/rtl/nwh_pkg.sv -----
// Shared types and constants for the nearest word by Hamming distance block.
`default_nettype none

package nwh_pkg;

  // Operation codes carried by an input item.
  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_CAND  = 1'b1;

  // Largest distance the result field can show.
  localparam logic [6:0] DIST_SAT = 7'd127;

  // One input item.
  typedef struct packed {
    logic       operation;
    logic [7:0] symbol;
    logic       end_of_word;
    logic       end_of_list;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] best_index;
    logic [6:0] best_distance;
  } out_item_t;

  // Control flags handed from the front stage to the scoring stage.
  typedef struct packed {
    logic valid;     // An item occupies the scoring stage.
    logic is_cand;   // Candidate character rather than query character.
    logic clear;     // Query character that starts a new query.
    logic in_range;  // Candidate position is below the length limit.
    logic in_query;  // Candidate position lies inside the stored query.
    logic word_end;  // Last character of the candidate word.
    logic list_end;  // Last character of the candidate list.
  } nwh_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/nwh_query_mem.sv -----
// Query character memory with one write port and one registered read port.
`default_nettype none

module nwh_query_mem
  import nwh_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64,
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [7:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output logic      [7:0]    rd_data_o
);

  logic [7:0] mem_q [MAX_LEN];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; the data register holds while the pipeline is frozen.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/nwh_front.sv -----
// Front stage: query bookkeeping, memory addressing and candidate position tracking.
`default_nettype none

module nwh_front
  import nwh_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64,
  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int unsigned LW = $clog2(MAX_LEN + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          in_valid_i,
  input  wire in_item_t      in_data_i,
  output logic               wr_en_o,
  output logic     [AW-1:0]  wr_addr_o,
  output logic     [7:0]     wr_data_o,
  output logic     [AW-1:0]  rd_addr_o,
  output nwh_ctl_t           ctl_o,
  output logic     [7:0]     sym_o,
  output logic     [LW-1:0]  tail_o
);

  logic [LW-1:0] qlen_q, qlen_d;
  logic [LW-1:0] pos_q, pos_d;
  logic          closed_q, closed_d;
  nwh_ctl_t      ctl_q, ctl_d;
  logic [LW-1:0] qbase;
  logic [LW-1:0] pos_inc;
  logic [LW-1:0] tail;
  logic          in_range;
  logic          word_end;
  logic          take;
  logic          is_cand;

  assign take     = adv_i & in_valid_i;
  assign is_cand  = (in_data_i.operation == OP_CAND);
  assign qbase    = closed_q ? '0 : qlen_q;
  assign in_range = (pos_q < LW'(MAX_LEN));
  assign pos_inc  = in_range ? (pos_q + LW'(1)) : pos_q;
  assign word_end = in_data_i.end_of_word | in_data_i.end_of_list;
  assign tail     = (qlen_q > pos_inc) ? (qlen_q - pos_inc) : '0;

  // Query characters go to the next free entry until the query is full.
  assign wr_en_o   = take & ~is_cand & (qbase < LW'(MAX_LEN));
  assign wr_addr_o = qbase[AW-1:0];
  assign wr_data_o = in_data_i.symbol;
  assign rd_addr_o = pos_q[AW-1:0];

  // Next state of the query and position counters.
  always_comb begin
    qlen_d   = qlen_q;
    pos_d    = pos_q;
    closed_d = closed_q;
    ctl_d    = '0;
    if (take) begin
      ctl_d.valid   = 1'b1;
      ctl_d.is_cand = is_cand;
      if (!is_cand) begin
        ctl_d.clear = closed_q;
        if (qbase < LW'(MAX_LEN)) begin
          qlen_d = qbase + LW'(1);
        end else begin
          qlen_d = qbase;
        end
        if (closed_q) begin
          pos_d = '0;
        end
        closed_d = in_data_i.end_of_word;
      end else begin
        closed_d       = 1'b1;
        ctl_d.in_range = in_range;
        ctl_d.in_query = (pos_q < qlen_q);
        ctl_d.word_end = word_end;
        ctl_d.list_end = in_data_i.end_of_list;
        pos_d          = word_end ? '0 : pos_inc;
      end
    end else if (adv_i) begin
      ctl_d = '0;
    end else begin
      ctl_d = ctl_q;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q   <= '0;
      pos_q    <= '0;
      closed_q <= 1'b1;
      ctl_q    <= '0;
    end else begin
      qlen_q   <= qlen_d;
      pos_q    <= pos_d;
      closed_q <= closed_d;
      ctl_q    <= ctl_d;
    end
  end

  // Payload passed along with the item.
  always_ff @(posedge clk_i) begin
    if (take) begin
      sym_o  <= in_data_i.symbol;
      tail_o <= tail;
    end
  end

  assign ctl_o = ctl_q;

endmodule

`default_nettype wire

// ----- hw/rtl/nwh_score.sv -----
// Scoring stage: mismatch count, best candidate tracking and the result register.
`default_nettype none

module nwh_score
  import nwh_pkg::*;
#(
  parameter int unsigned MAX_LEN   = 64,
  parameter int unsigned MAX_WORDS = 256,
  localparam int unsigned LW = $clog2(MAX_LEN + 1),
  localparam int unsigned WW = $clog2(MAX_WORDS + 1),
  localparam int unsigned IW = $clog2(MAX_WORDS)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire nwh_ctl_t      ctl_i,
  input  wire logic [7:0]    sym_i,
  input  wire logic [LW-1:0] tail_i,
  input  wire logic [7:0]    rd_data_i,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output out_item_t          out_data_o
);

  logic [LW-1:0]   run_q;
  logic [LW-1:0]   best_q;
  logic            none_q;
  logic [IW-1:0]   word_q;
  logic [WW-1:0]   wc_q;
  logic            out_valid_q;
  out_item_t       out_data_q;
  logic            mis;
  logic [LW-1:0]   run_new;
  logic [LW-1:0]   word_dist;
  logic            room;
  logic            better;
  logic [LW-1:0]   best_fin;
  logic [IW-1:0]   word_fin;
  logic [LW+6:0]   dist_ext;
  logic [IW+7:0]   idx_ext;
  logic            fire;
  logic            emit;

  // Distance of the word that ends with this character.
  assign mis       = ctl_i.in_range & (~ctl_i.in_query | (rd_data_i != sym_i));
  assign run_new   = run_q + LW'(mis);
  assign word_dist = run_new + tail_i;
  assign room      = (wc_q < WW'(MAX_WORDS));
  assign better    = ctl_i.word_end & room & (none_q | (word_dist < best_q));
  assign best_fin  = better ? word_dist : best_q;
  assign word_fin  = better ? wc_q[IW-1:0] : word_q;
  assign fire      = adv_i & ctl_i.valid;
  assign emit      = fire & ctl_i.is_cand & ctl_i.list_end;

  // Result fields: low index bits and a saturated distance.
  assign dist_ext = (LW + 7)'(best_fin);
  assign idx_ext  = (IW + 8)'(word_fin);

  // Search state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      best_q <= '1;
      none_q <= 1'b1;
      word_q <= '0;
      wc_q   <= '0;
    end else if (fire) begin
      if (!ctl_i.is_cand) begin
        if (ctl_i.clear) begin
          run_q  <= '0;
          best_q <= '1;
          none_q <= 1'b1;
          word_q <= '0;
          wc_q   <= '0;
        end
      end else if (ctl_i.word_end) begin
        run_q <= '0;
        if (ctl_i.list_end) begin
          best_q <= '1;
          none_q <= 1'b1;
          word_q <= '0;
          wc_q   <= '0;
        end else begin
          best_q <= best_fin;
          word_q <= word_fin;
          if (better) begin
            none_q <= 1'b0;
          end
          if (room) begin
            wc_q <= wc_q + WW'(1);
          end
        end
      end else begin
        run_q <= run_new;
      end
    end
  end

  // Result register; a stalled transfer holds its value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.best_index    <= idx_ext[7:0];
      out_data_q.best_distance <= (dist_ext > (LW + 7)'(DIST_SAT)) ? DIST_SAT : dist_ext[6:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_word_by_hamming.sv -----
// Top level of the nearest word by Hamming distance block.
//
// Input channel (in_valid_i, in_stall_o, in_data_i) carries one character per
// transfer: query characters build the stored query, candidate characters are
// compared against it. Output channel (out_valid_o, out_stall_i, out_data_o)
// carries one result on the last character of each candidate list: the index
// of the closest candidate (first one wins a tie) and its distance.
// Throughput is one character per cycle while in_stall_o is low. A result
// follows the transfer of the character that ends the list through the query
// memory read and front stage registers, then the scoring stage and result register.
// While a result waits in the output register and the receiver stalls, the
// pipeline keeps scoring characters; it freezes and raises in_stall_o only
// when the character that ends the next list reaches the scoring stage.
// Otherwise the input is never stalled. Reset empties the query and the
// search; the query memory itself is not cleared, and entries past the
// stored query are never used.
`default_nettype none

module nearest_word_by_hamming
  import nwh_pkg::*;
#(
  parameter int unsigned MAX_LEN   = 64,
  parameter int unsigned MAX_WORDS = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);

  logic          adv;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  nwh_ctl_t      ctl;
  logic [7:0]    sym;
  logic [LW-1:0] tail;

  // The pipeline moves unless a new result would overwrite one the receiver holds.
  assign adv        = ~(out_valid_o & out_stall_i & ctl.valid & ctl.is_cand & ctl.list_end);
  assign in_stall_o = ~adv;

  nwh_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd_addr_o  (rd_addr),
    .ctl_o      (ctl),
    .sym_o      (sym),
    .tail_o     (tail)
  );

  nwh_query_mem #(
    .MAX_LEN (MAX_LEN)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (adv),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nwh_score #(
    .MAX_LEN   (MAX_LEN),
    .MAX_WORDS (MAX_WORDS)
  ) u_score (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (ctl),
    .sym_i       (sym),
    .tail_i      (tail),
    .rd_data_i   (rd_data),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- dv/nearest_word_by_hamming_tb.sv -----
// Self-checking testbench for the nearest word by Hamming distance block.
`timescale 1ns / 100ps

module nearest_word_by_hamming_tb;
  import nwh_pkg::*;

  localparam int LEN_LIMIT      = 64;
  localparam int WORD_LIMIT     = 256;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 10;
  localparam logic [6:0] NO_BEST = 7'h7F;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  nearest_word_by_hamming #(
    .MAX_LEN  (LEN_LIMIT),
    .MAX_WORDS(WORD_LIMIT)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Shared test state.
  int errors          = 0;
  int items_sent      = 0;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int hold_reqs       = 0;
  int holds_done      = 0;
  int idle_cycles     = 0;

  // Query as the stimulus generator last sent it, used to build near matches.
  logic [7:0] gen_query [72];
  int         gen_qlen = 0;

  // Predicted state of the search.
  logic [7:0] q_chars [LEN_LIMIT];
  logic [6:0] q_len         = '0;
  logic       query_closed  = 1'b1;
  logic [6:0] cand_pos      = '0;
  logic [6:0] mismatches    = '0;
  logic [6:0] best_dist     = NO_BEST;
  logic [7:0] best_idx      = '0;
  logic [8:0] word_idx      = '0;

  out_item_t  nearest_q [$];
  out_item_t  want;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Forget the current list and candidate.
  task automatic restart_search();
    cand_pos   = '0;
    mismatches = '0;
    best_dist  = NO_BEST;
    best_idx   = '0;
    word_idx   = '0;
  endtask

  // Advance the predicted search by one character and queue the nearest word
  // whenever a list ends.
  task automatic score_character(input in_item_t item);
    logic [6:0] word_dist;
    out_item_t  res;
    if (item.operation == OP_QUERY) begin
      if (query_closed) begin
        q_len        = '0;
        query_closed = 1'b0;
        restart_search();
      end
      if (q_len < LEN_LIMIT) begin
        q_chars[q_len] = item.symbol;
        q_len++;
      end
      if (item.end_of_word) query_closed = 1'b1;
    end else begin
      query_closed = 1'b1;
      if (cand_pos < LEN_LIMIT) begin
        if (cand_pos >= q_len || q_chars[cand_pos] != item.symbol) mismatches++;
        cand_pos++;
      end
      if (item.end_of_word || item.end_of_list) begin
        // Query positions the candidate never reached count as mismatches.
        word_dist = mismatches + ((q_len > cand_pos) ? q_len - cand_pos : 7'd0);
        if (word_idx < WORD_LIMIT) begin
          if (best_dist == NO_BEST || word_dist < best_dist) begin
            best_dist = word_dist;
            best_idx  = word_idx[7:0];
          end
          word_idx++;
        end
        cand_pos   = '0;
        mismatches = '0;
        if (item.end_of_list) begin
          res.best_index    = best_idx;
          res.best_distance = best_dist;
          nearest_q.push_back(res);
          restart_search();
        end
      end
    end
  endtask

  // Check each result transfer and predict from each input transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (nearest_q.size() == 0) begin
          $error("unexpected result: best_index %0d best_distance %0d",
                 out_data_o.best_index, out_data_o.best_distance);
          errors++;
        end else begin
          want = nearest_q.pop_front();
          if (out_data_o.best_index !== want.best_index) begin
            $error("best_index: expected %0d, actual %0d",
                   want.best_index, out_data_o.best_index);
            errors++;
          end
          if (out_data_o.best_distance !== want.best_distance) begin
            $error("best_distance: expected %0d, actual %0d",
                   want.best_distance, out_data_o.best_distance);
            errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) score_character(in_data_i);
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever a test asks for one.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = holds_done + 1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one character and wait for its transfer.
  task automatic send_char(input logic op, input logic [7:0] sym,
                           input logic eow, input logic eol);
    in_item_t item;
    item.operation   = op;
    item.symbol      = sym;
    item.end_of_word = eow;
    item.end_of_list = eol;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // One round of random traffic: mostly a query and a list of near matches,
  // sometimes loose characters or a list that is abandoned.
  task automatic send_search_round();
    int         qlen;
    int         nwords;
    int         wlen;
    bit         broken;
    bit         last_char;
    bit         last_word;
    logic [7:0] sym;
    if ($urandom_range(99) < 10) begin
      repeat ($urandom_range(1, 4))
        send_char(1'($urandom_range(1)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      return;
    end
    // A new query most of the time; otherwise the stored one is searched again.
    if (gen_qlen == 0 || $urandom_range(99) < 70) begin
      qlen = ($urandom_range(99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (int i = 0; i < qlen; i++) begin
        gen_query[i] = 8'($urandom_range(255));
        send_char(OP_QUERY, gen_query[i], i == qlen - 1 && $urandom_range(99) < 90,
                  $urandom_range(99) < 10);
      end
      gen_qlen = qlen;
    end
    nwords = $urandom_range(1, 6);
    broken = ($urandom_range(99) < 5);
    for (int w = 0; w < nwords; w++) begin
      if ($urandom_range(99) < 4) wlen = $urandom_range(62, 72);
      else wlen = gen_qlen - 2 + $urandom_range(4);
      if (wlen < 1) wlen = 1;
      last_word = (w == nwords - 1) && !broken;
      for (int i = 0; i < wlen; i++) begin
        sym = (i < gen_qlen && $urandom_range(99) < 75) ? gen_query[i]
                                                        : 8'($urandom_range(255));
        last_char = (i == wlen - 1);
        // The list may also end on a character without its word marker.
        if (last_char && last_word && $urandom_range(99) < 15)
          send_char(OP_CAND, sym, 1'b0, 1'b1);
        else
          send_char(OP_CAND, sym, last_char, last_char && last_word);
      end
    end
  endtask

  // Candidates before any query: every position mismatches.
  task automatic test_empty_query();
    send_char(OP_CAND, 8'h41, 1'b1, 1'b1);
  endtask

  // Exact, short and long words, a tie, and a list ended without a word marker.
  task automatic test_distance_rules();
    // A list marker on a query character is ignored.
    send_char(OP_QUERY, 8'h01, 1'b0, 1'b1);
    send_char(OP_QUERY, 8'hFF, 1'b0, 1'b0);
    send_char(OP_QUERY, 8'h55, 1'b1, 1'b0);
    send_char(OP_CAND, 8'h01, 1'b0, 1'b0);
    send_char(OP_CAND, 8'hFF, 1'b0, 1'b0);
    send_char(OP_CAND, 8'h55, 1'b1, 1'b0);
    send_char(OP_CAND, 8'h01, 1'b0, 1'b0);
    send_char(OP_CAND, 8'hAA, 1'b1, 1'b0);
    send_char(OP_CAND, 8'h01, 1'b0, 1'b0);
    send_char(OP_CAND, 8'hFF, 1'b0, 1'b0);
    send_char(OP_CAND, 8'h55, 1'b0, 1'b0);
    send_char(OP_CAND, 8'h7E, 1'b1, 1'b1);
    // The query is kept for a second list; the earlier of two equal words wins.
    send_char(OP_CAND, 8'h02, 1'b1, 1'b0);
    send_char(OP_CAND, 8'h01, 1'b0, 1'b0);
    send_char(OP_CAND, 8'hFF, 1'b1, 1'b0);
    send_char(OP_CAND, 8'h01, 1'b0, 1'b0);
    send_char(OP_CAND, 8'h00, 1'b0, 1'b0);
    send_char(OP_CAND, 8'h55, 1'b0, 1'b1);
  endtask

  // A candidate closes an unfinished query; a new query drops a list in progress.
  task automatic test_query_rules();
    send_char(OP_QUERY, 8'h10, 1'b0, 1'b0);
    send_char(OP_CAND, 8'h10, 1'b1, 1'b1);
    send_char(OP_CAND, 8'h20, 1'b1, 1'b0);
    send_char(OP_QUERY, 8'h20, 1'b1, 1'b0);
    send_char(OP_CAND, 8'h21, 1'b1, 1'b1);
  endtask

  // Query and candidates longer than the length limit.
  task automatic test_length_limits();
    for (int i = 0; i < 70; i++) begin
      gen_query[i] = 8'($urandom_range(255));
      send_char(OP_QUERY, gen_query[i], i == 69, 1'b0);
    end
    gen_qlen = 70;
    for (int i = 0; i < 72; i++)
      send_char(OP_CAND, (i < 70) ? gen_query[i] : 8'($urandom_range(255)), i == 71, 1'b0);
    for (int i = 0; i < 10; i++)
      send_char(OP_CAND, gen_query[i], i == 9, 1'b0);
    for (int i = 0; i < 66; i++)
      send_char(OP_CAND, ~gen_query[i], i == 65, i == 65);
  endtask

  // A list longer than the word limit: words past it are not considered.
  task automatic test_word_limit();
    int hit;
    hit = $urandom_range(100, WORD_LIMIT - 1);
    send_char(OP_QUERY, 8'h5A, 1'b1, 1'b0);
    gen_query[0] = 8'h5A;
    gen_qlen     = 1;
    for (int w = 0; w < 300; w++)
      send_char(OP_CAND, (w == hit || w >= WORD_LIMIT) ? 8'h5A : 8'hA5 ^ 8'($urandom_range(3)),
                1'b1, w == 299);
  endtask

  // The receiver holds off while one-word lists keep coming, so results back
  // up and the block stalls its input.
  task automatic test_backpressure();
    sender_idle_pct = 0;
    stall_pct       = 0;
    hold_reqs <= hold_reqs + 1;
    repeat (8) send_char(OP_CAND, 8'($urandom_range(255)), 1'b1, 1'b1);
  endtask

  // Random search rounds under one idling pattern.
  task automatic test_random_searches(input int idle_pct, input int stall_in, input int count);
    int target;
    sender_idle_pct = idle_pct;
    stall_pct       = stall_in;
    target          = items_sent + count;
    while (items_sent < target) send_search_round();
  endtask

  // Test sequence.
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_query();
    test_distance_rules();
    test_query_rules();
    test_random_searches(0, 0, 370);
    test_length_limits();
    test_random_searches(76, 0, 370);
    test_backpressure();
    test_random_searches(0, 76, 370);
    test_word_limit();
    test_random_searches(7, 7, 370);
    in_valid_i <= 1'b0;
    stall_pct = 0;
    while (nearest_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
